### rtl/core/psd3_pkg.sv
// Package for the point to segment distance unit.
// Holds the fixed-point widths and the beat and pipeline types.
// No dependencies.
package psd3_pkg;

  localparam int CoordW = 24;               // signed Q15.8 coordinate
  localparam int FracW  = 16;               // fraction bits of the parameter
  localparam int MagW   = CoordW + 1;       // magnitude of a difference
  localparam int DotW   = 2 * MagW;         // dot products and their sums
  localparam int RemW   = DotW + 1;         // division remainder after shift
  localparam int ParW   = FracW + 1;        // parameter, one integer bit
  localparam int ProdW  = MagW + FracW;     // direction times parameter
  localparam int ErrW   = ProdW + 1 - FracW; // truncated error magnitude
  localparam int SqW    = 2 * ErrW;         // sum of squared errors
  localparam int RootW  = ErrW;             // square root width
  localparam int DistW  = 25;               // distance field

  localparam logic [ParW-1:0] TOne = ParW'(1) << FracW;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_z;
  } in_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [ParW-1:0]  param_t;
    logic             degenerate;
  } out_t;

  // Per axis: magnitudes of direction and offset, and whether their signs differ.
  typedef struct packed {
    logic [MagW-1:0] md;
    logic [MagW-1:0] mw;
    logic            neg;
  } axis_t;

  typedef axis_t [2:0] geo_t;

  typedef struct packed {
    logic [RemW-1:0]  r;
    logic [FracW-1:0] q;
    logic [DotW-1:0]  dd;
    logic             zero;
    logic             one;
    logic             degen;
    geo_t             geo;
  } div_t;

  typedef struct packed {
    logic [SqW-1:0]  n;
    logic [SqW-1:0]  res;
    logic [ParW-1:0] t;
    logic            degen;
  } root_t;

endpackage

### rtl/core/point_segment_distance_3d_unit.sv
// Point to segment distance in 3D, fully pipelined fixed-point datapath.
// Depends on psd3_pkg for widths and beat types.
//
// Channel | Direction | Handshake        | Payload
// item    | in        | start_i / busy_o | item_i   (psd3_pkg::in_t)
// result  | out       | done_o           | result_o (psd3_pkg::out_t)
//
// Every item passes through these stages from the accepting edge to its result beat:
// 5 setup stages, one stage per parameter bit of the restoring divider (16),
// 5 error stages and one stage per root bit of the square root (26), then
// the output register. A new item is accepted every cycle; busy_o stays low.
// Reset clears only the valid bits, so items in flight at reset are dropped.
// The receiver cannot stall, so the pipeline never holds.
module point_segment_distance_3d_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  psd3_pkg::in_t   item_i,
  output logic            done_o,
  output psd3_pkg::out_t  result_o
);
  import psd3_pkg::*;

  localparam int Latency = 5 + FracW + 5 + RootW + 1;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // ---------------- stage A: differences and magnitudes
  logic signed [MagW-1:0] d_s [3];
  logic signed [MagW-1:0] w_s [3];
  geo_t geo_a_d, geo_a_q;
  logic [CoordW-1:0] p_c [3];
  logic [CoordW-1:0] s_c [3];
  logic [CoordW-1:0] e_c [3];

  assign p_c[0] = item_i.point_x;
  assign p_c[1] = item_i.point_y;
  assign p_c[2] = item_i.point_z;
  assign s_c[0] = item_i.start_x;
  assign s_c[1] = item_i.start_y;
  assign s_c[2] = item_i.start_z;
  assign e_c[0] = item_i.end_x;
  assign e_c[1] = item_i.end_y;
  assign e_c[2] = item_i.end_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_s[i] = $signed({e_c[i][CoordW-1], e_c[i]}) - $signed({s_c[i][CoordW-1], s_c[i]});
      w_s[i] = $signed({p_c[i][CoordW-1], p_c[i]}) - $signed({s_c[i][CoordW-1], s_c[i]});
      geo_a_d[i].md  = d_s[i][MagW-1] ? MagW'(-d_s[i]) : MagW'(d_s[i]);
      geo_a_d[i].mw  = w_s[i][MagW-1] ? MagW'(-w_s[i]) : MagW'(w_s[i]);
      geo_a_d[i].neg = d_s[i][MagW-1] ^ w_s[i][MagW-1];
    end
  end

  // ---------------- stage B: products
  logic [DotW-1:0] dd_p_q [3];
  logic [DotW-1:0] wd_p_q [3];
  geo_t geo_b_q;

  // ---------------- stage C: sums
  logic [DotW-1:0] dd_c_d, pos_c_d, neg_c_d;
  logic [DotW-1:0] dd_c_q, pos_c_q, neg_c_q;
  geo_t geo_c_q;

  always_comb begin
    dd_c_d  = dd_p_q[0] + dd_p_q[1] + dd_p_q[2];
    pos_c_d = '0;
    neg_c_d = '0;
    for (int i = 0; i < 3; i++) begin
      if (geo_b_q[i].neg) begin
        neg_c_d = neg_c_d + wd_p_q[i];
      end else begin
        pos_c_d = pos_c_d + wd_p_q[i];
      end
    end
  end

  // ---------------- stage D: sign of the projection and remainder start
  logic [DotW-1:0] dd_d_q, r_d_q;
  logic            zero_d_q, degen_d_q;
  geo_t            geo_d_q;

  // ---------------- divider: div_q[0] is stage E, one quotient bit per stage
  div_t div_q [FracW+1];
  div_t div_e_d;
  logic [FracW:0] div_v_q;

  always_comb begin
    div_e_d       = '0;
    div_e_d.r     = RemW'(r_d_q);
    div_e_d.dd    = dd_d_q;
    div_e_d.zero  = zero_d_q;
    div_e_d.one   = (r_d_q >= dd_d_q);
    div_e_d.degen = degen_d_q;
    div_e_d.geo   = geo_d_q;
  end

  for (genvar k = 0; k < FracW; k++) begin : g_div
    div_t            nxt;
    logic [RemW-1:0] sh;
    always_comb begin
      nxt = div_q[k];
      sh  = {div_q[k].r[RemW-2:0], 1'b0};
      if (sh >= RemW'(div_q[k].dd)) begin
        nxt.r = sh - RemW'(div_q[k].dd);
        nxt.q = {div_q[k].q[FracW-2:0], 1'b1};
      end else begin
        nxt.r = sh;
        nxt.q = {div_q[k].q[FracW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      div_q[k+1] <= nxt;
    end
  end

  // ---------------- stage F: final parameter
  logic [ParW-1:0] t_f_d, t_f_q;
  logic            degen_f_q;
  geo_t            geo_f_q;

  always_comb begin
    if (div_q[FracW].zero) begin
      t_f_d = '0;
    end else if (div_q[FracW].one) begin
      t_f_d = TOne;
    end else begin
      t_f_d = {1'b0, div_q[FracW].q};
    end
  end

  // ---------------- stage G: direction times parameter
  logic [ProdW-1:0] a_g_q [3];
  logic [ParW-1:0]  t_g_q;
  logic             degen_g_q;
  geo_t             geo_g_q;

  // ---------------- stage H: error magnitudes, truncated to 8 fraction bits
  logic [ProdW:0]  em_full [3];
  logic [ProdW:0]  b_ext [3];
  logic [ErrW-1:0] em_h_q [3];
  logic [ParW-1:0] t_h_q;
  logic            degen_h_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b_ext[i] = {1'b0, geo_g_q[i].mw, {FracW{1'b0}}};
      if (geo_g_q[i].neg) begin
        em_full[i] = {1'b0, a_g_q[i]} + b_ext[i];
      end else if ({1'b0, a_g_q[i]} >= b_ext[i]) begin
        em_full[i] = {1'b0, a_g_q[i]} - b_ext[i];
      end else begin
        em_full[i] = b_ext[i] - {1'b0, a_g_q[i]};
      end
    end
  end

  // ---------------- stage I: squares
  logic [SqW-1:0]  sq_i_q [3];
  logic [ParW-1:0] t_i_q;
  logic            degen_i_q;

  // ---------------- square root: root_q[0] is stage J, one root bit per stage
  root_t root_q [RootW+1];
  root_t root_j_d;
  logic [RootW:0] root_v_q;

  always_comb begin
    root_j_d       = '0;
    root_j_d.n     = sq_i_q[0] + sq_i_q[1] + sq_i_q[2];
    root_j_d.t     = t_i_q;
    root_j_d.degen = degen_i_q;
  end

  for (genvar k = 0; k < RootW; k++) begin : g_root
    localparam logic [SqW-1:0] Bit = SqW'(1) << (SqW - 2 - 2 * k);
    root_t          nxt;
    logic [SqW-1:0] trial;
    always_comb begin
      nxt   = root_q[k];
      trial = root_q[k].res + Bit;
      if (root_q[k].n >= trial) begin
        nxt.n   = root_q[k].n - trial;
        nxt.res = (root_q[k].res >> 1) + Bit;
      end else begin
        nxt.res = root_q[k].res >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      root_q[k+1] <= nxt;
    end
  end

  // ---------------- valid bits
  logic v_a_q, v_b_q, v_c_q, v_d_q, v_f_q, v_g_q, v_h_q, v_i_q, v_o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q    <= 1'b0;
      v_b_q    <= 1'b0;
      v_c_q    <= 1'b0;
      v_d_q    <= 1'b0;
      div_v_q  <= '0;
      v_f_q    <= 1'b0;
      v_g_q    <= 1'b0;
      v_h_q    <= 1'b0;
      v_i_q    <= 1'b0;
      root_v_q <= '0;
      v_o_q    <= 1'b0;
    end else begin
      v_a_q    <= accept;
      v_b_q    <= v_a_q;
      v_c_q    <= v_b_q;
      v_d_q    <= v_c_q;
      div_v_q  <= {div_v_q[FracW-1:0], v_d_q};
      v_f_q    <= div_v_q[FracW];
      v_g_q    <= v_f_q;
      v_h_q    <= v_g_q;
      v_i_q    <= v_h_q;
      root_v_q <= {root_v_q[RootW-1:0], v_i_q};
      v_o_q    <= root_v_q[RootW];
    end
  end

  // ---------------- payload registers
  out_t res_o_q;

  always_ff @(posedge clk_i) begin
    geo_a_q <= geo_a_d;
    for (int i = 0; i < 3; i++) begin
      dd_p_q[i] <= DotW'(geo_a_q[i].md) * DotW'(geo_a_q[i].md);
      wd_p_q[i] <= DotW'(geo_a_q[i].md) * DotW'(geo_a_q[i].mw);
    end
    geo_b_q   <= geo_a_q;
    dd_c_q    <= dd_c_d;
    pos_c_q   <= pos_c_d;
    neg_c_q   <= neg_c_d;
    geo_c_q   <= geo_b_q;
    dd_d_q    <= dd_c_q;
    r_d_q     <= pos_c_q - neg_c_q;
    degen_d_q <= (dd_c_q == '0);
    zero_d_q  <= (dd_c_q == '0) || (pos_c_q <= neg_c_q);
    geo_d_q   <= geo_c_q;
    div_q[0]  <= div_e_d;
    t_f_q     <= t_f_d;
    degen_f_q <= div_q[FracW].degen;
    geo_f_q   <= div_q[FracW].geo;
    for (int i = 0; i < 3; i++) begin
      a_g_q[i] <= ProdW'(geo_f_q[i].md) * ProdW'(t_f_q);
    end
    t_g_q     <= t_f_q;
    degen_g_q <= degen_f_q;
    geo_g_q   <= geo_f_q;
    for (int i = 0; i < 3; i++) begin
      em_h_q[i] <= em_full[i][ProdW:FracW];
    end
    t_h_q     <= t_g_q;
    degen_h_q <= degen_g_q;
    for (int i = 0; i < 3; i++) begin
      sq_i_q[i] <= SqW'(em_h_q[i]) * SqW'(em_h_q[i]);
    end
    t_i_q     <= t_h_q;
    degen_i_q <= degen_h_q;
    root_q[0] <= root_j_d;
    res_o_q.distance   <= root_q[RootW].res[DistW-1:0];
    res_o_q.param_t    <= root_q[RootW].t;
    res_o_q.degenerate <= root_q[RootW].degen;
  end

  assign done_o   = v_o_q;
  assign result_o = res_o_q;

  // ---------------- assertions
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("result beat missing after item beat");

  a_degen_t : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.degenerate) |-> (result_o.param_t == '0))
    else $error("zero-length segment with non-zero parameter");

  a_t_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.param_t <= TOne))
    else $error("parameter above one");

endmodule
